// ===== sv/wros_pkg.sv =====
// ============================================================================
// wros_pkg
// Shared types and constants of the window ROI overlap scorer.
// ============================================================================
package wros_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WINDOW_DEFAULT = 16;
    localparam int COORD_BITS_DEFAULT = 13;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int CFG_W   = 5;
    localparam int SCORE_W = 16;

    // Window size after reset
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 5'd16;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_DECAY = 2'd1,
        CMD_SCORE = 2'd2
    } wros_cmd_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAKEROOM,
        ST_LOAD,
        ST_TRIM,
        ST_DROP,
        ST_SETTLE,
        ST_OVERLAP,
        ST_MULT,
        ST_DEN,
        ST_DIV,
        ST_DONE
    } wros_state_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } wros_cell_ctl_t;

endpackage

// ===== sv/wros_cell.sv =====
// ============================================================================
// wros_cell
// One window slot: holds a rectangle, shifts toward the oldest end on a
// drop, and merges its rectangle into the bounding box passing through.
// ============================================================================
module wros_cell
    import wros_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wros_cell_ctl_t        ctl,
    input  logic [COORD_BITS-1:0] new_x,
    input  logic [COORD_BITS-1:0] new_y,
    input  logic [COORD_BITS-1:0] new_w,
    input  logic [COORD_BITS-1:0] new_h,
    input  logic                  nbr_valid,
    input  logic [COORD_BITS-1:0] nbr_x,
    input  logic [COORD_BITS-1:0] nbr_y,
    input  logic [COORD_BITS-1:0] nbr_w,
    input  logic [COORD_BITS-1:0] nbr_h,
    output logic                  own_valid,
    output logic [COORD_BITS-1:0] own_x,
    output logic [COORD_BITS-1:0] own_y,
    output logic [COORD_BITS-1:0] own_w,
    output logic [COORD_BITS-1:0] own_h,
    input  logic                  box_in_any,
    input  logic [COORD_BITS-1:0] box_in_x0,
    input  logic [COORD_BITS-1:0] box_in_y0,
    input  logic [COORD_BITS:0]   box_in_x1,
    input  logic [COORD_BITS:0]   box_in_y1,
    output logic                  box_out_any,
    output logic [COORD_BITS-1:0] box_out_x0,
    output logic [COORD_BITS-1:0] box_out_y0,
    output logic [COORD_BITS:0]   box_out_x1,
    output logic [COORD_BITS:0]   box_out_y1
);

    localparam int SIDE_W = COORD_BITS + 1;

    logic                  valid_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [COORD_BITS-1:0] w_reg;
    logic [COORD_BITS-1:0] h_reg;

    logic                  any_reg;
    logic [COORD_BITS-1:0] x0_reg;
    logic [COORD_BITS-1:0] y0_reg;
    logic [SIDE_W-1:0]     x1_reg;
    logic [SIDE_W-1:0]     y1_reg;

    logic                  any_next;
    logic [COORD_BITS-1:0] x0_next;
    logic [COORD_BITS-1:0] y0_next;
    logic [SIDE_W-1:0]     x1_next;
    logic [SIDE_W-1:0]     y1_next;
    logic [SIDE_W-1:0]     end_x;
    logic [SIDE_W-1:0]     end_y;

    // Slot occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctl.shift)
        begin
            valid_reg <= nbr_valid;
        end
    end

    // Slot rectangle: load a new one or take the younger neighbor's
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg <= new_x;
            y_reg <= new_y;
            w_reg <= new_w;
            h_reg <= new_h;
        end
        else if (ctl.shift)
        begin
            x_reg <= nbr_x;
            y_reg <= nbr_y;
            w_reg <= nbr_w;
            h_reg <= nbr_h;
        end
    end

    // Merge this slot into the incoming box
    always_comb
    begin
        end_x    = SIDE_W'(x_reg) + SIDE_W'(w_reg);
        end_y    = SIDE_W'(y_reg) + SIDE_W'(h_reg);
        any_next = box_in_any;
        x0_next  = box_in_x0;
        y0_next  = box_in_y0;
        x1_next  = box_in_x1;
        y1_next  = box_in_y1;
        if (valid_reg)
        begin
            any_next = 1'b1;
            if (!box_in_any)
            begin
                x0_next = x_reg;
                y0_next = y_reg;
                x1_next = end_x;
                y1_next = end_y;
            end
            else
            begin
                x0_next = (x_reg < box_in_x0) ? x_reg : box_in_x0;
                y0_next = (y_reg < box_in_y0) ? y_reg : box_in_y0;
                x1_next = (end_x > box_in_x1) ? end_x : box_in_x1;
                y1_next = (end_y > box_in_y1) ? end_y : box_in_y1;
            end
        end
    end

    // Hand the running box to the next slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else
        begin
            any_reg <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= x0_next;
        y0_reg <= y0_next;
        x1_reg <= x1_next;
        y1_reg <= y1_next;
    end

    assign own_valid   = valid_reg;
    assign own_x       = x_reg;
    assign own_y       = y_reg;
    assign own_w       = w_reg;
    assign own_h       = h_reg;
    assign box_out_any = any_reg;
    assign box_out_x0  = x0_reg;
    assign box_out_y0  = y0_reg;
    assign box_out_x1  = x1_reg;
    assign box_out_y1  = y1_reg;

endmodule

// ===== sv/wros_div.sv =====
// ============================================================================
// wros_div
// Restoring divider, one quotient bit per cycle, for a fraction num/den
// with num below den.
// ============================================================================
module wros_div
    import wros_pkg::*;
#(
    parameter int NUM_W = 28,
    parameter int DEN_W = 29,
    parameter int Q_W   = SCORE_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    localparam int STEP_W = (Q_W > 1) ? $clog2(Q_W) : 1;

    logic              active_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [Q_W-1:0]    quot_reg;

    logic [DEN_W:0]    rem_dbl;
    logic              bit_set;
    logic [DEN_W:0]    rem_sub;
    logic [DEN_W-1:0]  rem_next;

    // One trial subtraction
    always_comb
    begin
        rem_dbl  = {rem_reg, 1'b0};
        bit_set  = (rem_dbl >= {1'b0, den_reg});
        rem_sub  = rem_dbl - {1'b0, den_reg};
        rem_next = bit_set ? rem_sub[DEN_W-1:0] : rem_dbl[DEN_W-1:0];
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else if (active_reg)
        begin
            if (step_reg == STEP_W'(Q_W - 1))
            begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= DEN_W'(num);
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (active_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[Q_W-2:0], bit_set};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== sv/window_roi_overlap_scorer.sv =====
// ============================================================================
// window_roi_overlap_scorer
// Sliding window of detection rectangles, its bounding box, and an
// overlap score of a query rectangle against that box.
// ============================================================================
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  in       | in_valid / in_stall   | command, rect_x, rect_y, rect_w, rect_h
//  out      | out_valid / out_stall | score, roi_x/y/w/h, window_empty
//  config   | window_size_we        | window_size
//
//  One request at a time. An add makes room when the window is full, loads
//  the entry, trims the oldest entries down to the window size and lets the
//  box sweep the cell chain; a decay drops the oldest entry and sweeps too.
//  A score finds the overlap, forms the products and runs the bit-serial
//  divider, skipping the divide when the query misses the region. Decay or
//  score on an empty window and the unused code go straight to the result.
//  Reset empties the window and sets window_size to 16.
//  A result waiting on out_stall holds; the next request is still taken and
//  its result waits until the result register frees.
//
module window_roi_overlap_scorer
    import wros_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT,
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  window_size_we,
    input  logic [CFG_W-1:0]      window_size,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CMD_W-1:0]      command,
    input  logic [COORD_BITS-1:0] rect_x,
    input  logic [COORD_BITS-1:0] rect_y,
    input  logic [COORD_BITS-1:0] rect_w,
    input  logic [COORD_BITS-1:0] rect_h,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SCORE_W-1:0]    score,
    output logic [COORD_BITS-1:0] roi_x,
    output logic [COORD_BITS-1:0] roi_y,
    output logic [COORD_BITS:0]   roi_w,
    output logic [COORD_BITS:0]   roi_h,
    output logic                  window_empty
);

    localparam int SIDE_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * SIDE_W;
    localparam int DEN_W  = PROD_W + 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    wros_state_t state_reg;
    wros_state_t state_next;

    logic [CFG_W-1:0]      window_size_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      wait_reg;
    logic [CNT_W-1:0]      wait_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic [COORD_BITS-1:0] q_x_reg;
    logic [COORD_BITS-1:0] q_y_reg;
    logic [COORD_BITS-1:0] q_w_reg;
    logic [COORD_BITS-1:0] q_h_reg;
    logic [CMD_W-1:0]      cmd_reg;

    logic [COORD_BITS-1:0] roi_x_reg;
    logic [COORD_BITS-1:0] roi_y_reg;
    logic [SIDE_W-1:0]     roi_w_reg;
    logic [SIDE_W-1:0]     roi_h_reg;

    logic [SIDE_W-1:0]     iw_reg;
    logic [SIDE_W-1:0]     ih_reg;
    logic                  ovl_ok_reg;
    logic [PROD_W-1:0]     inter_reg;
    logic [PROD_W-1:0]     a0_reg;
    logic [PROD_W-1:0]     a1_reg;
    logic [SCORE_W-1:0]    score_reg;

    logic [SCORE_W-1:0]    res_score_reg;
    logic [COORD_BITS-1:0] res_x_reg;
    logic [COORD_BITS-1:0] res_y_reg;
    logic [SIDE_W-1:0]     res_w_reg;
    logic [SIDE_W-1:0]     res_h_reg;
    logic                  res_empty_reg;

    logic                  accept;
    logic                  shift;
    logic                  load;
    logic                  div_start;
    logic                  roi_cap;
    logic                  res_load;
    logic [CNT_W-1:0]      lim;
    logic [CMP_W-1:0]      ws_ext;

    logic [SIDE_W-1:0]     rx1;
    logic [SIDE_W-1:0]     ry1;
    logic [SIDE_W-1:0]     qx1;
    logic [SIDE_W-1:0]     qy1;
    logic [SIDE_W-1:0]     hi_x;
    logic [SIDE_W-1:0]     hi_y;
    logic [COORD_BITS-1:0] lo_x;
    logic [COORD_BITS-1:0] lo_y;
    logic [SIDE_W:0]       diff_x;
    logic [SIDE_W:0]       diff_y;
    logic                  ovl_ok;
    logic [DEN_W-1:0]      den;

    logic                  div_done;
    logic [SCORE_W-1:0]    div_quot;

    // Cell chain wiring; the extra entry past the end is an empty slot
    wros_cell_ctl_t        cell_ctl [MAX_WINDOW];
    logic [MAX_WINDOW:0]   cell_valid;
    logic [COORD_BITS-1:0] cell_x [MAX_WINDOW+1];
    logic [COORD_BITS-1:0] cell_y [MAX_WINDOW+1];
    logic [COORD_BITS-1:0] cell_w [MAX_WINDOW+1];
    logic [COORD_BITS-1:0] cell_h [MAX_WINDOW+1];
    logic                  box_any [MAX_WINDOW+1];
    logic [COORD_BITS-1:0] box_x0 [MAX_WINDOW+1];
    logic [COORD_BITS-1:0] box_y0 [MAX_WINDOW+1];
    logic [SIDE_W-1:0]     box_x1 [MAX_WINDOW+1];
    logic [SIDE_W-1:0]     box_y1 [MAX_WINDOW+1];

    assign cell_valid[MAX_WINDOW] = 1'b0;
    assign cell_x[MAX_WINDOW]     = '0;
    assign cell_y[MAX_WINDOW]     = '0;
    assign cell_w[MAX_WINDOW]     = '0;
    assign cell_h[MAX_WINDOW]     = '0;
    assign box_any[0]             = 1'b0;
    assign box_x0[0]              = '0;
    assign box_y0[0]              = '0;
    assign box_x1[0]              = '0;
    assign box_y1[0]              = '0;

    // Slot k holds the k-th oldest rectangle
    for (genvar k = 0; k < MAX_WINDOW; k++)
    begin : g_cell
        assign cell_ctl[k].shift = shift;
        assign cell_ctl[k].load  = load && (count_reg == CNT_W'(k));

        wros_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl[k]),
            .new_x       (q_x_reg),
            .new_y       (q_y_reg),
            .new_w       (q_w_reg),
            .new_h       (q_h_reg),
            .nbr_valid   (cell_valid[k+1]),
            .nbr_x       (cell_x[k+1]),
            .nbr_y       (cell_y[k+1]),
            .nbr_w       (cell_w[k+1]),
            .nbr_h       (cell_h[k+1]),
            .own_valid   (cell_valid[k]),
            .own_x       (cell_x[k]),
            .own_y       (cell_y[k]),
            .own_w       (cell_w[k]),
            .own_h       (cell_h[k]),
            .box_in_any  (box_any[k]),
            .box_in_x0   (box_x0[k]),
            .box_in_y0   (box_y0[k]),
            .box_in_x1   (box_x1[k]),
            .box_in_y1   (box_y1[k]),
            .box_out_any (box_any[k+1]),
            .box_out_x0  (box_x0[k+1]),
            .box_out_y0  (box_y0[k+1]),
            .box_out_x1  (box_x1[k+1]),
            .box_out_y1  (box_y1[k+1])
        );
    end

    // Clamp the window size to 1..MAX_WINDOW
    always_comb
    begin
        ws_ext = CMP_W'(window_size_reg);
        if (window_size_reg == '0)
        begin
            lim = CNT_W'(1);
        end
        else if (ws_ext > CMP_W'(MAX_WINDOW))
        begin
            lim = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            lim = CNT_W'(ws_ext);
        end
    end

    // Overlap extents of the query against the region
    always_comb
    begin
        rx1    = SIDE_W'(roi_x_reg) + roi_w_reg;
        ry1    = SIDE_W'(roi_y_reg) + roi_h_reg;
        qx1    = SIDE_W'(q_x_reg) + SIDE_W'(q_w_reg);
        qy1    = SIDE_W'(q_y_reg) + SIDE_W'(q_h_reg);
        hi_x   = (rx1 < qx1) ? rx1 : qx1;
        hi_y   = (ry1 < qy1) ? ry1 : qy1;
        lo_x   = (roi_x_reg > q_x_reg) ? roi_x_reg : q_x_reg;
        lo_y   = (roi_y_reg > q_y_reg) ? roi_y_reg : q_y_reg;
        diff_x = (SIDE_W+1)'(hi_x) - (SIDE_W+1)'(lo_x);
        diff_y = (SIDE_W+1)'(hi_y) - (SIDE_W+1)'(lo_y);
        ovl_ok = !diff_x[SIDE_W] && (diff_x != '0) && !diff_y[SIDE_W] && (diff_y != '0);
    end

    assign den = DEN_W'(a0_reg) + DEN_W'(a1_reg) - DEN_W'(inter_reg);

    wros_div #(
        .NUM_W (PROD_W),
        .DEN_W (DEN_W),
        .Q_W   (SCORE_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (inter_reg),
        .den   (den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign accept = in_valid && !in_stall;

    // Sequencer: next state and chain controls
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        wait_next  = wait_reg;
        shift      = 1'b0;
        load       = 1'b0;
        div_start  = 1'b0;
        roi_cap    = 1'b0;
        res_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_ADD:   state_next = ST_MAKEROOM;
                        CMD_DECAY: state_next = (count_reg != '0) ? ST_DROP : ST_DONE;
                        CMD_SCORE: state_next = (count_reg != '0) ? ST_OVERLAP : ST_DONE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_MAKEROOM:
            begin
                if (count_reg == CNT_W'(MAX_WINDOW))
                begin
                    shift      = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                load       = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_TRIM;
            end
            ST_TRIM:
            begin
                if (count_reg > lim)
                begin
                    shift      = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    wait_next  = '0;
                    state_next = ST_SETTLE;
                end
            end
            ST_DROP:
            begin
                shift      = 1'b1;
                count_next = count_reg - CNT_W'(1);
                wait_next  = '0;
                state_next = ST_SETTLE;
            end
            ST_SETTLE:
            begin
                if (wait_reg == CNT_W'(MAX_WINDOW))
                begin
                    roi_cap    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    wait_next = wait_reg + CNT_W'(1);
                end
            end
            ST_OVERLAP:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                state_next = ovl_ok_reg ? ST_DEN : ST_DONE;
            end
            ST_DEN:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register: hold while stalled, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            wait_reg        <= '0;
            out_valid_reg   <= 1'b0;
            window_size_reg <= WINDOW_SIZE_RST;
            roi_x_reg       <= '0;
            roi_y_reg       <= '0;
            roi_w_reg       <= '0;
            roi_h_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            if (window_size_we)
            begin
                window_size_reg <= window_size;
            end
            // Take the region from the end of the chain
            if (roi_cap)
            begin
                if (box_any[MAX_WINDOW])
                begin
                    roi_x_reg <= box_x0[MAX_WINDOW];
                    roi_y_reg <= box_y0[MAX_WINDOW];
                    roi_w_reg <= box_x1[MAX_WINDOW] - SIDE_W'(box_x0[MAX_WINDOW]);
                    roi_h_reg <= box_y1[MAX_WINDOW] - SIDE_W'(box_y0[MAX_WINDOW]);
                end
                else
                begin
                    roi_x_reg <= '0;
                    roi_y_reg <= '0;
                    roi_w_reg <= '0;
                    roi_h_reg <= '0;
                end
            end
        end
    end

    // Request capture and score datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            q_x_reg   <= rect_x;
            q_y_reg   <= rect_y;
            q_w_reg   <= rect_w;
            q_h_reg   <= rect_h;
            score_reg <= '0;
        end
        if (state_reg == ST_OVERLAP)
        begin
            iw_reg     <= diff_x[SIDE_W-1:0];
            ih_reg     <= diff_y[SIDE_W-1:0];
            ovl_ok_reg <= ovl_ok;
        end
        if (state_reg == ST_MULT)
        begin
            inter_reg <= PROD_W'(iw_reg) * PROD_W'(ih_reg);
            a0_reg    <= PROD_W'(roi_w_reg + SIDE_W'(1)) * PROD_W'(roi_h_reg + SIDE_W'(1));
            a1_reg    <= PROD_W'(SIDE_W'(q_w_reg) + SIDE_W'(1))
                         * PROD_W'(SIDE_W'(q_h_reg) + SIDE_W'(1));
        end
        if (div_done && (cmd_reg == CMD_SCORE))
        begin
            score_reg <= div_quot;
        end
        if (res_load)
        begin
            res_score_reg <= score_reg;
            res_x_reg     <= roi_x_reg;
            res_y_reg     <= roi_y_reg;
            res_w_reg     <= roi_w_reg;
            res_h_reg     <= roi_h_reg;
            res_empty_reg <= (count_reg == '0);
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign score        = res_score_reg;
    assign roi_x        = res_x_reg;
    assign roi_y        = res_y_reg;
    assign roi_w        = res_w_reg;
    assign roi_h        = res_h_reg;
    assign window_empty = res_empty_reg;

    // Occupied slots form a prefix of the chain matching the count
    a_count_matches_slots: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid[MAX_WINDOW-1:0]) == int'(count_reg))
        else $error("slot occupancy disagrees with entry count");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_WINDOW))
        else $error("entry count above window depth");

    a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (count_reg < CNT_W'(MAX_WINDOW)))
        else $error("load into a full window");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_empty_result_zero_roi: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_empty_reg) |-> (res_w_reg == '0) && (res_h_reg == '0))
        else $error("empty window reported with a nonzero region");

endmodule
